@@ hdl/hbe_pkg.sv @@
// ----------------------------------------------------------------------------
// hbe_pkg: shared definitions for the binary max-heap block
// Sizes, item codes, status codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package hbe_pkg;

  localparam int DEPTH   = 1024;
  localparam int VALUE_W = 16;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_BUILD   = 2'd1,
    MODE_EXTRACT = 2'd2,
    MODE_RSVD    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  // Heap store access: one write port, two read ports
  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic [ADDR_W-1:0]  raddr_a;
    logic [ADDR_W-1:0]  raddr_b;
  } ram_req_t;

  // Finished result handed from the sequencer to the output stage
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] max_value;
    status_t            status;
    logic [COUNT_W-1:0] count_after;
  } res_t;

endpackage

@@ hdl/hbe_if.sv @@
// ----------------------------------------------------------------------------
// hbe_if: item channels of the binary max-heap block
// Input channel carries mode and value; result channel carries the result.
// ----------------------------------------------------------------------------
interface hbe_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [hbe_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface hbe_out_if;
  logic                        valid;
  logic                        ready;
  logic [hbe_pkg::VALUE_W-1:0] max_value;
  logic [1:0]                  status;
  logic [hbe_pkg::COUNT_W-1:0] count_after;

  modport source (output valid, output max_value, output status, output count_after,
                  input ready);
  modport sink   (input valid, input max_value, input status, input count_after,
                  output ready);
endinterface

@@ hdl/binary_max_heap_build_extract.sv @@
// ----------------------------------------------------------------------------
// binary_max_heap_build_extract: array-backed binary max-heap
// Load, build and extract-maximum over a 1024-entry heap store.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per valid/ready handshake: mode (load, build,
//   extract, reserved) and value. out_ch returns exactly one result per
//   item: max_value, status and count_after, in item order.
//   Items are worked one at a time by a sequencer over a synchronous store
//   with one write and two read ports. Load, reserved and empty or full
//   cases go from the idle state straight to the done state. Extract reads
//   the root and the last element, then walks sift-down, L being the number
//   of levels the new root descends; each level takes a child read state
//   and a compare and write-back state. Build runs the same walk for every
//   internal node, from the last internal node down to the root.
//   The next item is accepted once the result has moved to the output
//   register, even while the receiver still stalls on it; that next result
//   then waits in the sequencer until the output register frees up.
//   Reset clears the element count and the handshake state; store contents
//   are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module binary_max_heap_build_extract (
  input  logic     clk,
  input  logic     rst_n,
  hbe_in_if.sink   in_ch,
  hbe_out_if.source out_ch
);

  hbe_pkg::ram_req_t           req;
  logic [hbe_pkg::VALUE_W-1:0] rd_a, rd_b;
  hbe_pkg::res_t               res;
  logic                        res_take;

  logic                        out_valid_r;
  logic [hbe_pkg::VALUE_W-1:0] out_max_r;
  hbe_pkg::status_t            out_st_r;
  logic [hbe_pkg::COUNT_W-1:0] out_cnt_r;

  hbe_ram u_ram (
    .clk  (clk),
    .req  (req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  hbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .req      (req),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .res      (res),
    .res_take (res_take)
  );

  // Move a finished result into the output register when it is free
  assign res_take = res.valid && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_max_r <= res.max_value;
      out_st_r  <= res.status;
      out_cnt_r <= res.count_after;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.max_value   = out_max_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.count_after = out_cnt_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.count_after <= hbe_pkg::COUNT_W'(hbe_pkg::DEPTH)))
    else $error("count_after exceeds store depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == hbe_pkg::ST_FULL))
      |-> (out_ch.count_after == hbe_pkg::COUNT_W'(hbe_pkg::DEPTH)))
    else $error("load-on-full flagged while store not full");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == hbe_pkg::ST_EMPTY))
      |-> ((out_ch.count_after == '0) && (out_ch.max_value == '0)))
    else $error("extract-on-empty with nonzero count or value");

  a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> (out_ch.valid && (out_ch.count_after == $past(res.count_after))))
    else $error("result lost on its way to the output register");

endmodule

@@ hdl/hbe_ram.sv @@
// ----------------------------------------------------------------------------
// hbe_ram: heap store
// Synchronous memory, one write port and two read ports, registered reads.
// ----------------------------------------------------------------------------
module hbe_ram (
  input  logic                        clk,
  input  hbe_pkg::ram_req_t           req,
  output logic [hbe_pkg::VALUE_W-1:0] rd_a,
  output logic [hbe_pkg::VALUE_W-1:0] rd_b
);

  logic [hbe_pkg::VALUE_W-1:0] mem [hbe_pkg::DEPTH];

  // Write and read; reads see data written in earlier cycles
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule

@@ hdl/hbe_ctrl.sv @@
// ----------------------------------------------------------------------------
// hbe_ctrl: heap sequencer
// Decodes items, keeps the element count and walks sift-down over the store.
// ----------------------------------------------------------------------------
module hbe_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  hbe_in_if.sink                      in_ch,
  output hbe_pkg::ram_req_t           req,
  input  logic [hbe_pkg::VALUE_W-1:0] rd_a,
  input  logic [hbe_pkg::VALUE_W-1:0] rd_b,
  output hbe_pkg::res_t               res,
  input  logic                        res_take
);

  localparam int AW  = hbe_pkg::ADDR_W;
  localparam int CW  = hbe_pkg::COUNT_W;
  localparam int VW  = hbe_pkg::VALUE_W;
  localparam int CHW = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLD_LD,
    S_EX_LD,
    S_SD_RD,
    S_SD_EV,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    node_r, node_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic [VW-1:0]    cur_r, cur_nxt;
  logic             bld_r, bld_nxt;
  logic [VW-1:0]    res_max_r, res_max_nxt;
  hbe_pkg::status_t res_st_r, res_st_nxt;

  logic [CHW-1:0] left_w, right_w, lim_w;
  logic           l_win, r_win, moved;
  logic [VW-1:0]  pick_val, child_val;
  logic [AW-1:0]  pick_addr;

  // Children of the current node and the larger-child pick
  assign left_w    = {1'b0, node_r, 1'b1};
  assign right_w   = left_w + CHW'(1);
  assign lim_w     = {{(CHW - CW){1'b0}}, count_r};
  assign l_win     = (left_w < lim_w) && (cur_r < rd_a);
  assign pick_val  = l_win ? rd_a : cur_r;
  assign r_win     = (right_w < lim_w) && (pick_val < rd_b);
  assign moved     = l_win || r_win;
  assign child_val = r_win ? rd_b : rd_a;
  assign pick_addr = r_win ? right_w[AW-1:0] : left_w[AW-1:0];

  // Next state and store access
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    node_nxt    = node_r;
    k_nxt       = k_r;
    cur_nxt     = cur_r;
    bld_nxt     = bld_r;
    res_max_nxt = res_max_r;
    res_st_nxt  = res_st_r;
    in_ch.ready = 1'b0;
    req.we      = 1'b0;
    req.waddr   = node_r;
    req.wdata   = cur_r;
    req.raddr_a = left_w[AW-1:0];
    req.raddr_b = right_w[AW-1:0];

    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          res_max_nxt = '0;
          res_st_nxt  = hbe_pkg::ST_OK;
          state_nxt   = S_DONE;
          case (hbe_pkg::mode_t'(in_ch.mode))
            hbe_pkg::MODE_LOAD: begin
              if (count_r == CW'(hbe_pkg::DEPTH)) begin
                res_st_nxt = hbe_pkg::ST_FULL;
              end else begin
                req.we    = 1'b1;
                req.waddr = count_r[AW-1:0];
                req.wdata = in_ch.value;
                count_nxt = count_r + CW'(1);
              end
            end
            hbe_pkg::MODE_BUILD: begin
              // Start at the last internal node
              if (count_r >= CW'(2)) begin
                k_nxt       = AW'(count_r >> 1) - AW'(1);
                req.raddr_a = k_nxt;
                bld_nxt     = 1'b1;
                state_nxt   = S_BLD_LD;
              end
            end
            hbe_pkg::MODE_EXTRACT: begin
              if (count_r == '0) begin
                res_st_nxt = hbe_pkg::ST_EMPTY;
              end else begin
                req.raddr_a = '0;
                req.raddr_b = AW'(count_r - CW'(1));
                bld_nxt     = 1'b0;
                state_nxt   = S_EX_LD;
              end
            end
            default: begin
              res_st_nxt = hbe_pkg::ST_RSVD;
            end
          endcase
        end
      end
      S_BLD_LD: begin
        cur_nxt   = rd_a;
        node_nxt  = k_r;
        state_nxt = S_SD_RD;
      end
      S_EX_LD: begin
        // Old root is the result; last element moves to the root
        res_max_nxt = rd_a;
        cur_nxt     = rd_b;
        node_nxt    = '0;
        count_nxt   = count_r - CW'(1);
        state_nxt   = S_SD_RD;
      end
      S_SD_RD: begin
        state_nxt = S_SD_EV;
      end
      S_SD_EV: begin
        req.we = 1'b1;
        if (moved) begin
          // Pull the larger child up and descend
          req.wdata = child_val;
          node_nxt  = pick_addr;
          state_nxt = S_SD_RD;
        end else if (bld_r && (k_r != '0)) begin
          k_nxt       = k_r - AW'(1);
          req.raddr_a = k_nxt;
          state_nxt   = S_BLD_LD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state; payload registers carry no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    node_r    <= node_nxt;
    k_r       <= k_nxt;
    cur_r     <= cur_nxt;
    bld_r     <= bld_nxt;
    res_max_r <= res_max_nxt;
    res_st_r  <= res_st_nxt;
  end

  assign res.valid       = (state_r == S_DONE);
  assign res.max_value   = res_max_r;
  assign res.status      = res_st_r;
  assign res.count_after = count_r;

endmodule
